FILE: sv/dnle_pkg.sv
// Shared types and constants for the DNS name label encoder.
`default_nettype none
package dnle_pkg;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND
    } dnle_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;  // input item taken this cycle
        logic fetch;   // read the first byte pair of the label
        logic load;    // move the fetched pair into the output register
    } dnle_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic closes;    // the offered item closes a label
        logic out_free;  // output register can take a pair this cycle
        logic more;      // further pairs follow the one being loaded
    } dnle_status_t;

endpackage
`default_nettype wire

FILE: sv/dnle_ctrl.sv
// Controller state machine: accept, fetch and send sequencing.
`default_nettype none
module dnle_ctrl
    import dnle_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire dnle_status_t status,
    output dnle_cmd_t         cmd
);

    dnle_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.closes) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (status.out_free) begin
                    cmd.load = 1'b1;
                    if (!status.more) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/dnle_dpath.sv
// Datapath: label buffer, counters, pair assembly and output register.
`default_nettype none
module dnle_dpath
    import dnle_pkg::*;
#(
    parameter int MAX_LABEL = 63
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [7:0]   in_char,
    input  wire logic         in_final,
    input  wire dnle_cmd_t    cmd,
    output dnle_status_t      status,
    input  wire logic         m_tready,
    output logic              m_tvalid,
    output logic [15:0]       m_tdata,
    output logic              m_tlast,
    output logic [1:0]        m_tuser
);

    localparam int CW = $clog2(MAX_LABEL + 1);
    localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int NW = $clog2(MAX_LABEL + 4);
    localparam int JW = NW + 1;

    logic [7:0]    label_mem [MAX_LABEL];

    logic [CW-1:0] count_reg;
    logic          overlong_reg;
    logic [CW-1:0] emit_cnt_reg;
    logic [NW-1:0] total_reg;
    logic          fin_reg;
    logic          flag_reg;
    logic [NW-1:0] pair_reg;
    logic [7:0]    rd0_reg, rd1_reg;

    logic          out_valid_reg;
    logic [15:0]   out_data_reg;
    logic          out_last_reg;
    logic [1:0]    out_user_reg;

    logic          is_dot, room, drop;
    logic [CW-1:0] cnt_after;
    logic          flag_after;
    logic [NW-1:0] total_after;

    logic          rd_en;
    logic [NW-1:0] pair_rd;
    logic [JW-1:0] idx0, idx1;

    logic [JW-1:0] j0, j1, jn, cnt_j;
    logic [7:0]    byte0, byte1;
    logic          has2, more;

    assign is_dot     = (in_char == DOT_CHAR);
    assign room       = (count_reg < CW'(MAX_LABEL));
    assign drop       = !is_dot && !room;
    assign cnt_after  = (!is_dot && room) ? count_reg + CW'(1) : count_reg;
    assign flag_after = overlong_reg | drop;

    always_comb begin
        if (is_dot && in_final) begin
            total_after = NW'(cnt_after) + NW'(3);
        end else if (in_final) begin
            total_after = NW'(cnt_after) + NW'(2);
        end else begin
            total_after = NW'(cnt_after) + NW'(1);
        end
    end

    // label buffer write and count/error bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.accept && !is_dot && room) begin
            label_mem[count_reg[AW-1:0]] <= in_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overlong_reg <= 1'b0;
        end else if (cmd.accept) begin
            if (is_dot || in_final) begin
                count_reg <= '0;
            end else begin
                count_reg <= cnt_after;
            end
            overlong_reg <= in_final ? 1'b0 : flag_after;
        end
    end

    // snapshot of the closing label
    always_ff @(posedge aclk) begin
        if (cmd.accept && (is_dot || in_final)) begin
            emit_cnt_reg <= cnt_after;
            total_reg    <= total_after;
            fin_reg      <= in_final;
            flag_reg     <= flag_after;
        end
    end

    // pair reads: pair p needs buffer entries 2p-1 and 2p
    assign more    = (jn < JW'(total_reg));
    assign rd_en   = cmd.fetch | (cmd.load & more);
    assign pair_rd = cmd.fetch ? '0 : pair_reg + NW'(1);
    assign idx1    = {pair_rd, 1'b0};
    assign idx0    = idx1 - JW'(1);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            pair_reg <= pair_rd;
            if (idx0 < JW'(MAX_LABEL)) begin
                rd0_reg <= label_mem[idx0[AW-1:0]];
            end else begin
                rd0_reg <= '0;
            end
            if (idx1 < JW'(MAX_LABEL)) begin
                rd1_reg <= label_mem[idx1[AW-1:0]];
            end else begin
                rd1_reg <= '0;
            end
        end
    end

    // byte selection for the pair held in the read registers
    assign j0    = {pair_reg, 1'b0};
    assign j1    = j0 + JW'(1);
    assign jn    = j0 + JW'(2);
    assign cnt_j = JW'(emit_cnt_reg);
    assign has2  = (j1 < JW'(total_reg));

    always_comb begin
        if (j0 == '0) begin
            byte0 = 8'(emit_cnt_reg);
        end else if (j0 <= cnt_j) begin
            byte0 = rd0_reg;
        end else begin
            byte0 = '0;
        end
        if (j1 <= cnt_j) begin
            byte1 = rd1_reg;
        end else begin
            byte1 = '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_data_reg <= {has2 ? byte1 : 8'h00, byte0};
            out_last_reg <= fin_reg && !more;
            out_user_reg <= {flag_reg, has2};
        end
    end

    assign status.closes   = is_dot | in_final;
    assign status.out_free = !out_valid_reg | m_tready;
    assign status.more     = more;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule
`default_nettype wire

FILE: sv/dns_name_label_encoder_core.sv
// Top level of the DNS name label encoder: controller plus datapath.
//
// Usage: a dotted domain name enters one character per item on the s_
// channel (s_tdata = character, s_tlast = last character of the name).
// Ordinary characters are buffered in a label memory and produce nothing;
// they are taken one per cycle when idle. A dot, or the last character, closes the
// label: the block emits the length byte, the label bytes and, at the end
// of a name, an empty label for a trailing dot and the zero terminator.
// Bytes leave on the m_ channel packed two per item, low byte first;
// m_tuser[0] marks a valid second byte, m_tlast the item with the
// terminator, and m_tuser[1] a label longer than MAX_LABEL in this name
// (extra bytes are dropped and the length byte saturates at MAX_LABEL).
// Sequence: a closing item is accepted, the first pair is read from the
// label memory into the read registers, then loaded into the output
// register for m_. Throughput: one pair per cycle while m_tready allows,
// and a label closing L buffered bytes sends L + 1 + tail bytes (tail = 1
// for the terminator, 2 with a trailing dot) with s_tready held low until
// its last pair is loaded; the two-port label memory read sets this pace.
// Reset clears the control state and the error flag; label contents are
// kept in memory and need no clearing. When m_tready is low the current
// pair holds in the output register and the block waits without loss.
`default_nettype none
module dns_name_label_encoder_core
    import dnle_pkg::*;
#(
    parameter int MAX_LABEL = 63
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] name_char
    input  wire logic        s_tlast,   // final_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] first_byte, [15:8] second_byte
    output logic             m_tlast,   // end_of_name
    output logic [1:0]       m_tuser    // [0] second_valid, [1] label_too_long
);

    dnle_cmd_t    cmd;
    dnle_status_t status;

    // sequencing: idle/accept, fetch first pair, send pairs
    dnle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // label buffer, bookkeeping and output register
    dnle_dpath #(
        .MAX_LABEL (MAX_LABEL)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_char  (s_tdata),
        .in_final (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

FILE: sv/dnle_checker.sv
// Port-level checker for the DNS name label encoder, with its bind.
`default_nettype none
module dnle_checker
    import dnle_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [1:0]  m_tuser
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // an item that closes a label stops intake for the fetch
    a_close_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata == DOT_CHAR || s_tlast) |=> !s_tready)
        else $error("intake continued after label close");

    // unused second byte is zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[15:8] == 8'h00)
        else $error("unused second byte not zero");

    // the last byte of a name is the zero terminator
    a_terminator: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tuser[0] ? (m_tdata[15:8] == 8'h00)
                                            : (m_tdata[7:0] == 8'h00)))
        else $error("name does not end in terminator");

endmodule

bind dns_name_label_encoder_core dnle_checker u_dnle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
